>>> src/vpnt_pkg.sv
// Shared constants, types and codes of the vertex position and normal transform.
package vpnt_pkg;

  // Fixed-point formats
  localparam int MFB = 16;             // fraction bits of matrix entries and positions
  localparam int NFB = 14;             // fraction bits of normals

  // Matrix store
  localparam int NENT = 12;
  localparam int IDXW = 4;

  // Normal path widths
  localparam int DW   = 82;            // signed cofactor-times-normal sum
  localparam int BLW  = $clog2(DW + 1);
  localparam int VW   = 30;            // normalized component magnitude
  localparam int SUMW = 2 * VW + 2;    // sum of three squares
  localparam int LENW = VW + 1;        // floor square root of that sum
  localparam int QW   = NFB + 1;       // quotient never exceeds 2^NFB
  localparam int DNW  = LENW + NFB + 1; // dividend and shifted divisor

  // Pipelined square root and divide
  localparam int SQ_PER = 2;
  localparam int SQ_STG = (LENW + SQ_PER - 1) / SQ_PER;
  localparam int DV_PER = 3;
  localparam int DV_STG = (QW + DV_PER - 1) / DV_PER;

  // Cofactor and determinant refresh after a matrix write
  localparam int DERIVE_LAT = 4;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_VERTEX = 1'b1
  } cmd_e;

  // Matrix and its derived values, as seen by the vertex pipeline
  typedef struct packed {
    logic [8:0][31:0] lin;     // column-major linear part
    logic [2:0][31:0] trans;
    logic [8:0][63:0] cof;     // cofactor row r, column c at r*3+c
    logic             det_neg;
    logic             det_zero;
  } mat_t;

  // Per-vertex side data that travels along the pipeline
  typedef struct packed {
    logic [2:0][15:0]   norm;
    logic               has_normal;
    logic [2:0][31:0]   pos;
    logic [2:0]         sg;
    logic               nz;
    logic [2:0][VW-1:0] v;
  } carry_t;

  typedef struct packed {
    logic [SUMW-1:0] rem;
    logic [SUMW-1:0] res;
  } sq_t;

  typedef struct packed {
    logic [2:0][DNW-1:0] rem;
    logic [2:0][QW-1:0]  q;
    logic [LENW-1:0]     len;
    logic                kept;
  } dv_t;

endpackage

>>> src/vpnt_matrix.sv
// Matrix store with pipelined cofactor and determinant refresh.
module vpnt_matrix (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      we_i,
  input  logic [vpnt_pkg::IDXW-1:0] widx_i,
  input  logic [31:0]               wdata_i,
  output vpnt_pkg::mat_t            mat_o,
  output logic                      busy_o
);
  import vpnt_pkg::*;

  // Store indices of the two products of each cofactor
  localparam int CA [9] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
  localparam int CB [9] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
  localparam int CC [9] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
  localparam int CD [9] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};
  localparam logic [31:0] ONE = 32'(64'd1 << MFB);

  logic [31:0]            store_q [NENT];
  logic [2:0]             cnt_q;
  logic signed [63:0]     pa_d [9], pa_q [9], pb_d [9], pb_q [9];
  logic signed [63:0]     cof_d [9], cof_q [9];
  logic signed [63:0]     dh_d [3], dh_q [3];
  logic signed [64:0]     dl_d [3], dl_q [3];
  logic signed [97:0]     det_d;
  logic                   det_neg_q, det_zero_q;

  // Store, reset to identity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NENT; i++) begin
        store_q[i] <= (i == 0 || i == 4 || i == 8) ? ONE : '0;
      end
    end else if (we_i && widx_i < IDXW'(NENT)) begin
      store_q[widx_i] <= wdata_i;
    end
  end

  // Refresh counter; reset starts a refresh too
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'(DERIVE_LAT);
    end else if (we_i) begin
      cnt_q <= 3'(DERIVE_LAT);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 3'd1;
    end
  end

  // Cofactor products, cofactors, determinant partials, determinant
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      pa_d[k]  = $signed(store_q[CA[k]]) * $signed(store_q[CB[k]]);
      pb_d[k]  = $signed(store_q[CC[k]]) * $signed(store_q[CD[k]]);
      cof_d[k] = pa_q[k] - pb_q[k];
    end
    det_d = '0;
    for (int c = 0; c < 3; c++) begin
      dh_d[c] = $signed(store_q[c*3]) * $signed(cof_q[c][63:32]);
      dl_d[c] = $signed(store_q[c*3]) * $signed({1'b0, cof_q[c][31:0]});
      det_d   = det_d + (98'(dh_q[c]) <<< 32) + 98'(dl_q[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    pa_q       <= pa_d;
    pb_q       <= pb_d;
    cof_q      <= cof_d;
    dh_q       <= dh_d;
    dl_q       <= dl_d;
    det_neg_q  <= det_d[97];
    det_zero_q <= (det_d == '0);
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      mat_o.lin[i] = store_q[i];
      mat_o.cof[i] = cof_q[i];
    end
    for (int r = 0; r < 3; r++) begin
      mat_o.trans[r] = store_q[9 + r];
    end
    mat_o.det_neg  = det_neg_q;
    mat_o.det_zero = det_zero_q;
  end

  assign busy_o = (cnt_q != '0);

endmodule

>>> src/vpnt_front.sv
// Front pipeline: products, position result, normal direction, scaling, squares.
module vpnt_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      vld_i,
  input  logic [2:0][31:0]          pos_i,
  input  logic                      has_normal_i,
  input  logic [2:0][15:0]          norm_i,
  input  vpnt_pkg::mat_t            mat_i,
  output logic                      vld_o,
  output vpnt_pkg::carry_t          car_o,
  output logic [vpnt_pkg::SUMW-1:0] sum_o,
  output logic                      busy_o
);
  import vpnt_pkg::*;

  logic [6:0]              vld_q;
  carry_t                  car_d [7], car_q [7];
  logic signed [63:0]      pp_d [3][3], pp_q [3][3];
  logic signed [47:0]      nh_d [3][3], nh_q [3][3];
  logic signed [48:0]      nl_d [3][3], nl_q [3][3];
  logic signed [65:0]      ps_d [3], ps_q [3];
  logic signed [DW-1:0]    d_d [3], d_q [3];
  logic [DW-1:0]           mag_d [3], mag_q [3], mag4_q [3];
  logic [BLW-1:0]          sh_d, sh_q;
  logic [2*VW-1:0]         sq_d [3], sq_q [3];
  logic [SUMW-1:0]         sum_d, sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[5:0], vld_i};
    end
  end

  always_comb begin
    logic signed [65:0] acc;
    logic signed [66:0] tsum;
    logic [DW-1:0]      orv;
    logic [BLW-1:0]     bl;

    // stage 1: all products
    car_d[0]            = '0;
    car_d[0].norm       = norm_i;
    car_d[0].has_normal = has_normal_i;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        pp_d[r][c] = $signed(mat_i.lin[c*3+r]) * $signed(pos_i[c]);
        nh_d[r][c] = $signed(mat_i.cof[r*3+c][63:32]) * $signed(norm_i[c]);
        nl_d[r][c] = $signed({1'b0, mat_i.cof[r*3+c][31:0]}) * $signed(norm_i[c]);
      end
    end

    // stage 2: rounded position sums and normal direction
    car_d[1] = car_q[0];
    for (int r = 0; r < 3; r++) begin
      acc = 66'(pp_q[r][0]) + 66'(pp_q[r][1]) + 66'(pp_q[r][2])
          + (66'sd1 <<< (MFB - 1));
      ps_d[r] = acc >>> MFB;
      d_d[r]  = '0;
      for (int c = 0; c < 3; c++) begin
        d_d[r] = d_d[r] + (DW'(nh_q[r][c]) <<< 32) + DW'(nl_q[r][c]);
      end
    end

    // stage 3: translation and saturation; direction magnitude and sign
    car_d[2] = car_q[1];
    for (int r = 0; r < 3; r++) begin
      tsum = 67'(ps_q[r]) + 67'($signed(mat_i.trans[r]));
      if (tsum > 67'sd2147483647) begin
        car_d[2].pos[r] = 32'h7FFF_FFFF;
      end else if (tsum < -67'sd2147483648) begin
        car_d[2].pos[r] = 32'h8000_0000;
      end else begin
        car_d[2].pos[r] = tsum[31:0];
      end
      mag_d[r] = d_q[r][DW-1] ? DW'(-d_q[r]) : DW'(d_q[r]);
      // mirrored flips the direction
      car_d[2].sg[r] = mat_i.det_neg ? (d_q[r] != '0 && !d_q[r][DW-1]) : d_q[r][DW-1];
    end

    // stage 4: common shift from the widest magnitude
    car_d[3] = car_q[2];
    orv = mag_q[0] | mag_q[1] | mag_q[2];
    bl  = '0;
    for (int i = 0; i < DW; i++) begin
      if (orv[i]) bl = BLW'(i + 1);
    end
    sh_d        = (bl > BLW'(VW)) ? bl - BLW'(VW) : '0;
    car_d[3].nz = (orv != '0);

    // stage 5: scale down
    car_d[4] = car_q[3];
    for (int r = 0; r < 3; r++) begin
      car_d[4].v[r] = VW'(mag4_q[r] >> sh_q);
    end

    // stage 6: squares
    car_d[5] = car_q[4];
    for (int r = 0; r < 3; r++) begin
      sq_d[r] = (2*VW)'(car_q[4].v[r]) * (2*VW)'(car_q[4].v[r]);
    end

    // stage 7: sum of squares
    car_d[6] = car_q[5];
    sum_d    = SUMW'(sq_q[0]) + SUMW'(sq_q[1]) + SUMW'(sq_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      car_q  <= car_d;
      pp_q   <= pp_d;
      nh_q   <= nh_d;
      nl_q   <= nl_d;
      ps_q   <= ps_d;
      d_q    <= d_d;
      mag_q  <= mag_d;
      mag4_q <= mag_q;
      sh_q   <= sh_d;
      sq_q   <= sq_d;
      sum_q  <= sum_d;
    end
  end

  assign vld_o  = vld_q[6];
  assign car_o  = car_q[6];
  assign sum_o  = sum_q;
  assign busy_o = |vld_q;

endmodule

>>> src/vpnt_isqrt.sv
// Pipelined floor square root of the sum of squares, two result bits per stage.
module vpnt_isqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      vld_i,
  input  vpnt_pkg::carry_t          car_i,
  input  logic [vpnt_pkg::SUMW-1:0] sum_i,
  output logic                      vld_o,
  output vpnt_pkg::carry_t          car_o,
  output logic [vpnt_pkg::LENW-1:0] len_o,
  output logic                      busy_o
);
  import vpnt_pkg::*;

  logic [SQ_STG-1:0] vld_q;
  sq_t               st_d [SQ_STG], st_q [SQ_STG];
  carry_t            car_q [SQ_STG];

  // A few digit steps of the shift-subtract root
  function automatic sq_t sq_stage(sq_t x, int base);
    logic [SUMW-1:0] bitv;
    logic [SUMW-1:0] trial;
    sq_t             y;
    y = x;
    for (int j = 0; j < SQ_PER; j++) begin
      if (base + j < LENW) begin
        bitv  = SUMW'(1) << (2 * (LENW - 1 - (base + j)));
        trial = y.res + bitv;
        if (y.rem >= trial) begin
          y.rem = y.rem - trial;
          y.res = (y.res >> 1) + bitv;
        end else begin
          y.res = y.res >> 1;
        end
      end
    end
    return y;
  endfunction

  always_comb begin
    sq_t src;
    for (int s = 0; s < SQ_STG; s++) begin
      if (s == 0) begin
        src.rem = sum_i;
        src.res = '0;
      end else begin
        src = st_q[s-1];
      end
      st_d[s] = sq_stage(src, s * SQ_PER);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[SQ_STG-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q     <= st_d;
      car_q[0] <= car_i;
      for (int s = 1; s < SQ_STG; s++) begin
        car_q[s] <= car_q[s-1];
      end
    end
  end

  assign vld_o  = vld_q[SQ_STG-1];
  assign car_o  = car_q[SQ_STG-1];
  assign len_o  = LENW'(st_q[SQ_STG-1].res);
  assign busy_o = |vld_q;

endmodule

>>> src/vpnt_div.sv
// Pipelined restoring divide of the three components by the length, and output register.
module vpnt_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      vld_i,
  input  vpnt_pkg::carry_t          car_i,
  input  logic [vpnt_pkg::LENW-1:0] len_i,
  input  logic                      det_zero_i,
  output logic                      vld_o,
  output logic [2:0][31:0]          pos_o,
  output logic [2:0][15:0]          norm_o,
  output logic                      kept_o,
  output logic                      busy_o
);
  import vpnt_pkg::*;

  localparam int NS = DV_STG + 1;   // prepare stage plus divide stages

  logic [NS-1:0]     vld_q;
  dv_t               dv_d [NS], dv_q [NS];
  carry_t            car_q [NS];
  logic              out_vld_q;
  logic [2:0][31:0]  pos_q;
  logic [2:0][15:0]  norm_d, norm_q;
  logic              kept_q;

  function automatic dv_t dv_stage(dv_t x, int base);
    logic [DNW-1:0] dvs;
    dv_t            y;
    y = x;
    for (int j = 0; j < DV_PER; j++) begin
      if (base + j < QW) begin
        dvs = DNW'(y.len) << (QW - 1 - (base + j));
        for (int r = 0; r < 3; r++) begin
          if (y.rem[r] >= dvs) begin
            y.rem[r]                 = y.rem[r] - dvs;
            y.q[r][QW-1-(base + j)]  = 1'b1;
          end
        end
      end
    end
    return y;
  endfunction

  always_comb begin
    logic [15:0] mag;
    // prepare: dividend with half the divisor for rounding
    dv_d[0]      = '0;
    dv_d[0].len  = len_i;
    dv_d[0].kept = !car_i.has_normal || det_zero_i || !car_i.nz || (len_i == '0);
    for (int r = 0; r < 3; r++) begin
      dv_d[0].rem[r] = (DNW'(car_i.v[r]) << NFB) + DNW'(len_i >> 1);
    end
    for (int s = 1; s < NS; s++) begin
      dv_d[s] = dv_stage(dv_q[s-1], (s - 1) * DV_PER);
    end
    // limit, restore sign, or pass the input normal
    for (int r = 0; r < 3; r++) begin
      mag = (32'(dv_q[NS-1].q[r]) > 32'd32767) ? 16'd32767 : 16'(dv_q[NS-1].q[r]);
      if (dv_q[NS-1].kept) begin
        norm_d[r] = car_q[NS-1].norm[r];
      end else begin
        norm_d[r] = car_q[NS-1].sg[r] ? 16'(-mag) : mag;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q     <= {vld_q[NS-2:0], vld_i};
      out_vld_q <= vld_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_q     <= dv_d;
      car_q[0] <= car_i;
      for (int s = 1; s < NS; s++) begin
        car_q[s] <= car_q[s-1];
      end
      pos_q  <= car_q[NS-1].pos;
      norm_q <= norm_d;
      kept_q <= dv_q[NS-1].kept;
    end
  end

  assign vld_o  = out_vld_q;
  assign pos_o  = pos_q;
  assign norm_o = norm_q;
  assign kept_o = kept_q;
  assign busy_o = (|vld_q) | out_vld_q;

endmodule

>>> src/vertex_position_normal_transform.sv
// Top level: affine vertex transform with inverse-transpose normals.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------------------------
//  in      | input     | in_valid_i / in_stall_o    | cmd, entry_index/value, pos, has_normal, norm
//  out     | output    | out_valid_o / out_stall_i  | out_pos, out_norm, normal_kept, mirrored
//
// Vertex requests enter one per cycle while in_stall_o is low; each result passes
// through the front, the 16-stage root and 5-stage divide pipelines and the output register.
// A load request waits until no vertex is in flight, then blocks vertices and loads
// while cofactors and determinant are refreshed.
// After reset the same refresh runs before the first vertex.
// A stalled output register freezes the whole pipeline; nothing is lost or repeated.
module vertex_position_normal_transform (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      cmd_i,
  input  logic [3:0]                entry_index_i,
  input  logic signed [31:0]        entry_value_i,
  input  logic signed [31:0]        pos_x_i,
  input  logic signed [31:0]        pos_y_i,
  input  logic signed [31:0]        pos_z_i,
  input  logic                      has_normal_i,
  input  logic signed [15:0]        norm_x_i,
  input  logic signed [15:0]        norm_y_i,
  input  logic signed [15:0]        norm_z_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [31:0]        out_pos_x_o,
  output logic signed [31:0]        out_pos_y_o,
  output logic signed [31:0]        out_pos_z_o,
  output logic signed [15:0]        out_norm_x_o,
  output logic signed [15:0]        out_norm_y_o,
  output logic signed [15:0]        out_norm_z_o,
  output logic                      normal_kept_o,
  output logic                      mirrored_o
);
  import vpnt_pkg::*;

  mat_t             mat;
  carry_t           fr_car, sq_car;
  logic [SUMW-1:0]  fr_sum;
  logic [LENW-1:0]  sq_len;
  logic             fr_vld, sq_vld, dv_vld;
  logic             fr_busy, sq_busy, dv_busy, mat_busy, pipe_busy;
  logic             adv, load_acc, vtx_acc;
  logic [2:0][31:0] pos_out;
  logic [2:0][15:0] norm_out;

  // Pipeline advances unless the output register is full and stalled
  assign adv       = !(dv_vld && out_stall_i);
  assign pipe_busy = fr_busy | sq_busy | dv_busy;

  // Loads wait for an empty pipeline; vertices wait for the refresh
  assign in_stall_o = mat_busy || !adv || (cmd_e'(cmd_i) == CMD_LOAD && pipe_busy);
  assign load_acc   = in_valid_i && !in_stall_o && cmd_e'(cmd_i) == CMD_LOAD;
  assign vtx_acc    = in_valid_i && !in_stall_o && cmd_e'(cmd_i) == CMD_VERTEX;

  vpnt_matrix u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (load_acc),
    .widx_i  (entry_index_i),
    .wdata_i (entry_value_i),
    .mat_o   (mat),
    .busy_o  (mat_busy)
  );

  vpnt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (adv),
    .vld_i        (vtx_acc),
    .pos_i        ({pos_z_i, pos_y_i, pos_x_i}),
    .has_normal_i (has_normal_i),
    .norm_i       ({norm_z_i, norm_y_i, norm_x_i}),
    .mat_i        (mat),
    .vld_o        (fr_vld),
    .car_o        (fr_car),
    .sum_o        (fr_sum),
    .busy_o       (fr_busy)
  );

  vpnt_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (fr_vld),
    .car_i  (fr_car),
    .sum_i  (fr_sum),
    .vld_o  (sq_vld),
    .car_o  (sq_car),
    .len_o  (sq_len),
    .busy_o (sq_busy)
  );

  vpnt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .vld_i      (sq_vld),
    .car_i      (sq_car),
    .len_i      (sq_len),
    .det_zero_i (mat.det_zero),
    .vld_o      (dv_vld),
    .pos_o      (pos_out),
    .norm_o     (norm_out),
    .kept_o     (normal_kept_o),
    .busy_o     (dv_busy)
  );

  assign out_valid_o  = dv_vld;
  assign out_pos_x_o  = pos_out[0];
  assign out_pos_y_o  = pos_out[1];
  assign out_pos_z_o  = pos_out[2];
  assign out_norm_x_o = norm_out[0];
  assign out_norm_y_o = norm_out[1];
  assign out_norm_z_o = norm_out[2];
  // matrix cannot change while a result is held
  assign mirrored_o   = mat.det_neg;

endmodule

>>> test/vpnt_checker.sv
// Checker for the vertex transform: tracks the matrix, predicts results and compares.
module vpnt_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               cmd_i,
  input  logic [3:0]         entry_index_i,
  input  logic signed [31:0] entry_value_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic               has_normal_i,
  input  logic signed [15:0] norm_x_i,
  input  logic signed [15:0] norm_y_i,
  input  logic signed [15:0] norm_z_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [31:0] out_pos_x_i,
  input  logic signed [31:0] out_pos_y_i,
  input  logic signed [31:0] out_pos_z_i,
  input  logic signed [15:0] out_norm_x_i,
  input  logic signed [15:0] out_norm_y_i,
  input  logic signed [15:0] out_norm_z_i,
  input  logic               normal_kept_i,
  input  logic               mirrored_i,
  output int                 err_cnt_o,
  output int                 pending_o,
  output int                 vertex_cnt_o,
  output int                 load_cnt_o,
  output int                 renorm_cnt_o,
  output int                 mirror_cnt_o
);
  import vpnt_pkg::*;

  typedef struct {
    logic signed [31:0] pos [3];
    logic signed [15:0] norm [3];
    logic               kept;
    logic               mirr;
  } vertex_out_t;

  logic signed [31:0] matrix [NENT];
  vertex_out_t        expected_q [$];

  assign pending_o = expected_q.size();

  function automatic int bit_length(logic [127:0] x);
    int n;
    n = 0;
    for (int i = 0; i < 128; i++) if (x[i]) n = i + 1;
    return n;
  endfunction

  // floor square root, bit by bit
  function automatic logic [63:0] floor_sqrt(logic [63:0] x);
    logic [63:0] res, bitv;
    res  = '0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // transform one vertex with the current matrix
  function automatic vertex_out_t transform_vertex(logic signed [31:0] p [3],
                                                   logic hn, logic signed [15:0] n [3]);
    vertex_out_t        o;
    logic signed [31:0] lm [3][3];
    longint             cf [3][3];
    logic signed [127:0] acc, det;
    logic [127:0]       mag [3];
    logic               sg [3];
    logic [63:0]        v [3];
    logic [63:0]        sum, len, q;
    int                 bl, s;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) lm[r][c] = matrix[c * 3 + r];
    // position: exact sum, round half up, add translation, saturate
    for (int r = 0; r < 3; r++) begin
      acc = '0;
      for (int c = 0; c < 3; c++) acc = acc + lm[r][c] * p[c];
      acc = (acc + 128'sd32768) >>> MFB;
      acc = acc + matrix[9 + r];
      if (acc > 128'sh7FFFFFFF) o.pos[r] = 32'sh7FFFFFFF;
      else if (acc < -128'sh80000000) o.pos[r] = 32'sh80000000;
      else o.pos[r] = acc[31:0];
    end
    // cofactors wrap at 64 bits like the hardware
    cf[0][0] = longint'(lm[1][1]) * lm[2][2] - longint'(lm[1][2]) * lm[2][1];
    cf[0][1] = longint'(lm[1][2]) * lm[2][0] - longint'(lm[1][0]) * lm[2][2];
    cf[0][2] = longint'(lm[1][0]) * lm[2][1] - longint'(lm[1][1]) * lm[2][0];
    cf[1][0] = longint'(lm[0][2]) * lm[2][1] - longint'(lm[0][1]) * lm[2][2];
    cf[1][1] = longint'(lm[0][0]) * lm[2][2] - longint'(lm[0][2]) * lm[2][0];
    cf[1][2] = longint'(lm[0][1]) * lm[2][0] - longint'(lm[0][0]) * lm[2][1];
    cf[2][0] = longint'(lm[0][1]) * lm[1][2] - longint'(lm[0][2]) * lm[1][1];
    cf[2][1] = longint'(lm[0][2]) * lm[1][0] - longint'(lm[0][0]) * lm[1][2];
    cf[2][2] = longint'(lm[0][0]) * lm[1][1] - longint'(lm[0][1]) * lm[1][0];
    det = '0;
    for (int c = 0; c < 3; c++) det = det + lm[0][c] * cf[0][c];
    o.mirr = det < 0;
    o.kept = 1'b1;
    for (int r = 0; r < 3; r++) o.norm[r] = n[r];
    if (hn && det != 0) begin
      bl = 0;
      for (int r = 0; r < 3; r++) begin
        acc = '0;
        for (int c = 0; c < 3; c++) acc = acc + cf[r][c] * n[c];
        if (o.mirr) acc = -acc;
        sg[r]  = acc < 0;
        mag[r] = sg[r] ? -acc : acc;
        if (bit_length(mag[r]) > bl) bl = bit_length(mag[r]);
      end
      if (bl != 0) begin
        s   = bl > VW ? bl - VW : 0;
        sum = '0;
        for (int r = 0; r < 3; r++) begin
          v[r] = 64'(mag[r] >> s);
          sum  = sum + v[r] * v[r];
        end
        len = floor_sqrt(sum);
        if (len != 0) begin
          o.kept = 1'b0;
          for (int r = 0; r < 3; r++) begin
            q = ((v[r] << NFB) + len / 2) / len;
            if (q > 64'd32767) q = 64'd32767;
            o.norm[r] = sg[r] ? -q[15:0] : q[15:0];
          end
        end
      end
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    err_cnt_o++;
  endtask

  // sample at the falling edge: the request is taken at the next rising edge
  always @(negedge clk_i or negedge rst_ni) begin
    vertex_out_t        e;
    logic signed [31:0] p [3];
    logic signed [15:0] n [3];
    if (!rst_ni) begin
      for (int i = 0; i < NENT; i++) matrix[i] = '0;
      matrix[0] = 32'sd1 <<< MFB;
      matrix[4] = 32'sd1 <<< MFB;
      matrix[8] = 32'sd1 <<< MFB;
      expected_q.delete();
      err_cnt_o    = 0;
      vertex_cnt_o = 0;
      load_cnt_o   = 0;
      renorm_cnt_o = 0;
      mirror_cnt_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        if (cmd_i == CMD_LOAD) begin
          load_cnt_o++;
          if (entry_index_i < NENT) matrix[entry_index_i] = entry_value_i;
        end else begin
          p = '{pos_x_i, pos_y_i, pos_z_i};
          n = '{norm_x_i, norm_y_i, norm_z_i};
          e = transform_vertex(p, has_normal_i, n);
          vertex_cnt_o++;
          if (!e.kept) renorm_cnt_o++;
          if (e.mirr) mirror_cnt_o++;
          expected_q = {expected_q, e};
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          e = expected_q.pop_front();
          if (out_pos_x_i != e.pos[0]) report_mismatch("out_pos_x", out_pos_x_i, e.pos[0]);
          if (out_pos_y_i != e.pos[1]) report_mismatch("out_pos_y", out_pos_y_i, e.pos[1]);
          if (out_pos_z_i != e.pos[2]) report_mismatch("out_pos_z", out_pos_z_i, e.pos[2]);
          if (out_norm_x_i != e.norm[0]) report_mismatch("out_norm_x", out_norm_x_i, e.norm[0]);
          if (out_norm_y_i != e.norm[1]) report_mismatch("out_norm_y", out_norm_y_i, e.norm[1]);
          if (out_norm_z_i != e.norm[2]) report_mismatch("out_norm_z", out_norm_z_i, e.norm[2]);
          if (normal_kept_i != e.kept) report_mismatch("normal_kept", normal_kept_i, e.kept);
          if (mirrored_i != e.mirr) report_mismatch("mirrored", mirrored_i, e.mirr);
        end
      end
    end
  end

endmodule

>>> test/tb_vertex_position_normal_transform.sv
// Testbench top: drives vertex and matrix load requests and gives the verdict.
module tb_vertex_position_normal_transform;
  import vpnt_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int TAIL_WAIT  = 80;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  cmd_e               cmd = CMD_LOAD;
  logic [3:0]         entry_index = '0;
  logic signed [31:0] entry_value = '0;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic               has_normal = 1'b0;
  logic signed [15:0] norm_x = '0, norm_y = '0, norm_z = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [15:0] out_norm_x, out_norm_y, out_norm_z;
  logic               normal_kept, mirrored;
  int                 send_idle = 0, recv_idle = 0;
  int                 idle_cycles = 0;
  int                 err_cnt, pending, vertex_cnt, load_cnt, renorm_cnt, mirror_cnt;

  always #10 clk_i = ~clk_i;

  vertex_position_normal_transform dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .cmd_i(cmd), .entry_index_i(entry_index), .entry_value_i(entry_value),
    .pos_x_i(pos_x), .pos_y_i(pos_y), .pos_z_i(pos_z), .has_normal_i(has_normal),
    .norm_x_i(norm_x), .norm_y_i(norm_y), .norm_z_i(norm_z),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_pos_x_o(out_pos_x), .out_pos_y_o(out_pos_y), .out_pos_z_o(out_pos_z),
    .out_norm_x_o(out_norm_x), .out_norm_y_o(out_norm_y), .out_norm_z_o(out_norm_z),
    .normal_kept_o(normal_kept), .mirrored_o(mirrored)
  );

  vpnt_checker chk (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall), .cmd_i(cmd),
    .entry_index_i(entry_index), .entry_value_i(entry_value),
    .pos_x_i(pos_x), .pos_y_i(pos_y), .pos_z_i(pos_z), .has_normal_i(has_normal),
    .norm_x_i(norm_x), .norm_y_i(norm_y), .norm_z_i(norm_z),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .out_pos_x_i(out_pos_x), .out_pos_y_i(out_pos_y), .out_pos_z_i(out_pos_z),
    .out_norm_x_i(out_norm_x), .out_norm_y_i(out_norm_y), .out_norm_z_i(out_norm_z),
    .normal_kept_i(normal_kept), .mirrored_i(mirrored),
    .err_cnt_o(err_cnt), .pending_o(pending), .vertex_cnt_o(vertex_cnt),
    .load_cnt_o(load_cnt), .renorm_cnt_o(renorm_cnt), .mirror_cnt_o(mirror_cnt)
  );

  // receiver stalls at random
  always @(posedge clk_i) out_stall <= $urandom_range(0, 99) < recv_idle;

  // watchdog: cycles with no request or result taken
  always @(negedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // present one request after a random gap; return once it is taken
  task automatic wait_taken();
    logic taken;
    do begin
      @(negedge clk_i);
      taken = !in_stall;
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic send_gap();
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic send_load(logic [3:0] idx, logic signed [31:0] val);
    send_gap();
    in_valid    <= 1'b1;
    cmd         <= CMD_LOAD;
    entry_index <= idx;
    entry_value <= val;
    pos_x       <= $urandom;
    has_normal  <= 1'($urandom_range(0, 1));
    norm_x      <= 16'($urandom);
    wait_taken();
  endtask

  task automatic send_vertex(logic signed [31:0] px, py, pz, logic hn,
                             logic signed [15:0] nx, ny, nz);
    send_gap();
    in_valid    <= 1'b1;
    cmd         <= CMD_VERTEX;
    entry_index <= 4'($urandom);
    entry_value <= $urandom;
    pos_x       <= px;
    pos_y       <= py;
    pos_z       <= pz;
    has_normal  <= hn;
    norm_x      <= nx;
    norm_y      <= ny;
    norm_z      <= nz;
    wait_taken();
  endtask

  // mix of full-range, modest and extreme Q16.16 values
  function automatic logic signed [31:0] pick_q16();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return 32'(($urandom_range(0, 4) == 0) ? 32'h80000000 : 32'h7FFFFFFF);
      2:       return $urandom_range(0, 1) ? 32'sh00010000 : 32'sh0;
      default: return $signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000;
    endcase
  endfunction

  function automatic logic signed [15:0] pick_norm();
    case ($urandom_range(0, 7))
      0:       return 16'sh0;
      1:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      2:       return $urandom_range(0, 1) ? 16'sh4000 : -16'sh4000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 12)
        send_load(4'($urandom_range(0, 15)), pick_q16());
      else
        send_vertex(pick_q16(), pick_q16(), pick_q16(), $urandom_range(0, 3) != 0,
                    pick_norm(), pick_norm(), pick_norm());
    end
  endtask

  initial begin
    int wait_cnt;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: identity matrix, field extremes, missing normal, zero normal
    send_idle = 28;
    recv_idle = 71;
    send_vertex(32'sh00010000, -32'sh00020000, 32'sh0, 1'b1, 16'sh4000, 16'sh0, 16'sh0);
    send_vertex(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 1'b1,
                16'sh7FFF, 16'sh8000, 16'sh7FFF);
    send_vertex(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 1'b0,
                16'sh8000, 16'sh7FFF, 16'sh8000);
    send_vertex(32'sh12345678, 32'shFFFFFFFF, 32'sh1, 1'b1, 16'sh0, 16'sh0, 16'sh0);
    // out-of-range indexes are ignored
    for (int i = NENT; i < 16; i++) send_load(4'(i), 32'shDEADBEEF);
    // mirrored: negate x, add translation
    send_load(0, -32'sh00010000);
    send_load(9, 32'sh7FFFFFFF);
    send_vertex(32'sh00030000, 32'sh1, -32'sh8000, 1'b1, 16'sh1000, 16'sh2000, -16'sh3000);
    // singular linear part: normal is kept
    send_load(4, 32'sh0);
    send_vertex(32'sh00010000, 32'sh00010000, 32'sh00010000, 1'b1,
                16'sh0100, 16'sh0200, 16'sh0300);
    // extreme entries
    send_load(0, 32'sh80000000);
    send_load(4, 32'sh7FFFFFFF);
    send_load(8, 32'sh80000000);
    send_load(3, 32'sh7FFFFFFF);
    send_load(10, 32'sh80000000);
    send_vertex(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 1'b1,
                16'sh7FFF, 16'sh8000, 16'sh0001);
    // back to identity for the random part
    for (int i = 0; i < NENT; i++)
      send_load(4'(i), (i == 0 || i == 4 || i == 8) ? 32'sh00010000 : 32'sh0);

    random_phase(280);
    send_idle = 71;
    recv_idle = 28;
    random_phase(280);
    send_idle = 0;
    recv_idle = 0;
    random_phase(290);
    in_valid <= 1'b0;

    // drain; the watchdog bounds this wait
    while (pending != 0) @(posedge clk_i);
    wait_cnt = 0;
    while (wait_cnt < TAIL_WAIT) begin
      @(posedge clk_i);
      wait_cnt++;
    end

    $display("covered %0d vertices and %0d matrix loads", vertex_cnt, load_cnt);
    $display("%0d normals renormalized, %0d mirrored transforms, %0d mismatches",
             renorm_cnt, mirror_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
src/vpnt_pkg.sv
src/vpnt_matrix.sv
src/vpnt_front.sv
src/vpnt_isqrt.sv
src/vpnt_div.sv
src/vertex_position_normal_transform.sv
test/vpnt_checker.sv
test/tb_vertex_position_normal_transform.sv
